>>> design/u2c_pkg.sv
package u2c_pkg;

   localparam int TIME_WIDTH      = 63;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam int DIV_STAGES = 8;
   localparam int NUM_STAGES = 21;

   localparam int ST_UTC     = DIV_STAGES + 1;
   localparam int ST_LOCAL   = DIV_STAGES + 2;
   localparam int ST_DAY_HI  = DIV_STAGES + 3;
   localparam int ST_DAY_LO  = DIV_STAGES + 4;
   localparam int ST_SPLIT   = DIV_STAGES + 5;
   localparam int ST_CLOCK   = DIV_STAGES + 6;
   localparam int ST_NUM     = DIV_STAGES + 7;
   localparam int ST_YOE_HI  = DIV_STAGES + 8;
   localparam int ST_YOE_LO  = DIV_STAGES + 9;
   localparam int ST_DOY     = DIV_STAGES + 10;
   localparam int ST_MONTH   = DIV_STAGES + 11;
   localparam int ST_OUT     = DIV_STAGES + 12;

   // One microsecond divisor of 1000000 is applied as a shift by six and a division by 15625;
   // one day of 86400 seconds as a shift by seven and a division by 675.
   localparam logic [15:0] US_DIVISOR       = 16'd15625;
   localparam logic [15:0] DAY_DIVISOR      = 16'd675;
   localparam logic [15:0] SEC_PER_HOUR     = 16'd3600;
   localparam logic [15:0] SEC_PER_MINUTE   = 16'd60;
   localparam logic [15:0] DAYS_PER_4Y      = 16'd1460;
   localparam logic [15:0] DAYS_PER_YEAR    = 16'd365;
   localparam logic [15:0] MONTH_SPAN       = 16'd153;

   localparam logic [15:0] ERA_SPLIT_DAYS   = 16'd11017;
   localparam logic [17:0] ERA_HI_OFFSET    = 18'd11017;
   localparam logic [17:0] ERA_LO_OFFSET    = 18'd135080;
   localparam logic [11:0] ERA_HI_YEAR      = 12'd2000;
   localparam logic [11:0] ERA_LO_YEAR      = 12'd1600;
   localparam logic [17:0] DOE_CENTURY_1    = 18'd36524;
   localparam logic [17:0] DOE_CENTURY_2    = 18'd73048;
   localparam logic [17:0] DOE_CENTURY_3    = 18'd109572;
   localparam logic [17:0] DOE_LAST_DAY     = 18'd146096;
   localparam logic [17:0] YEAR_DAYS_MUL    = 18'd365;
   localparam logic [16:0] WEEKDAY_SHIFT    = 17'd4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SYNCED        = 3'd0,
      CSR_UNIX_SECONDS  = 3'd1,
      CSR_MONOTONIC_US  = 3'd2,
      CSR_ZONE_OFFSET   = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] rem;
      logic [7:0]  quo;
   } div8_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] utc;
      logic [32:0] loc;
      logic [15:0] days;
      logic [9:0]  drem;
      logic        era_hi;
      logic [17:0] doe;
      logic [4:0]  hour;
      logic [11:0] r3600;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic [6:0]  q1460;
      logic [2:0]  q36524;
      logic        last_day;
      logic [17:0] num;
      logic [7:0]  yq_hi;
      logic [8:0]  yrem;
      logic [8:0]  yoe;
      logic [8:0]  doy;
      logic [11:0] year_base;
      logic [3:0]  mp;
   } pipe_type;

   typedef struct packed {
      logic        valid_res;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } res_type;

   // Eight restoring division steps; the incoming remainder must be below the divisor.
   function automatic div8_type div8(input logic [15:0] rem, input logic [7:0] bits,
                                     input logic [15:0] divisor);
      logic [16:0] t;
      logic [15:0] r;
      div8_type    res;
      r   = rem;
      res = '0;
      for (int i = 7; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
            res.quo[i] = 1'b1;
         end else begin
            res.quo[i] = 1'b0;
         end
         r = t[15:0];
      end
      res.rem = r;
      return res;
   endfunction

   // Day of the March-based year on which each month starts.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

>>> design/unix_time_to_civil_clock_top.sv
// Converts a 63-bit monotonic microsecond timestamp into local civil date and time, using the
// sync snapshot and zone offset held in four configuration registers (write them only while no
// transfer is in flight; the write port is always ready). The block is a 21-stage pipeline: it
// takes one timestamp per clock unless req_stall holds the input, with the division of the
// elapsed microseconds by one million spread over eight stages of eight quotient bits each.
// Stall on the result side holds only as many stages as are full, so bubbles are squeezed out
// before the input is held.
// An unsynced block, a timestamp before the sync point or a negative local time gives
// valid_res low with every other field zero.
module unix_time_to_civil_clock_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [u2c_pkg::TIME_WIDTH-1:0]       req_now_microseconds,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid_res,
   output logic [11:0]                          rsp_year,
   output logic [3:0]                           rsp_month,
   output logic [4:0]                           rsp_day_of_month,
   output logic [4:0]                           rsp_hour,
   output logic [5:0]                           rsp_minute,
   output logic [5:0]                           rsp_second,
   output logic [2:0]                           rsp_weekday,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [u2c_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [u2c_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import u2c_pkg::*;

   logic                  synced_ff;
   logic [31:0]           unix_ff;
   logic [TIME_WIDTH-1:0] mono_ff;
   logic [10:0]           zone_ff;

   logic [NUM_STAGES-1:0] load;
   logic [NUM_STAGES-1:0] stage_valid;

   logic        ok_ff  [0:DIV_STAGES];
   logic [63:0] xp_ff  [0:DIV_STAGES];
   logic [13:0] rem_ff [0:DIV_STAGES];
   logic [31:0] q_ff   [0:DIV_STAGES];

   logic [63:0] diff_w;
   logic        ok0_in;
   logic [63:0] xp0_in;

   pipe_type p_ff [ST_UTC:ST_MONTH];
   pipe_type p_in [ST_UTC:ST_MONTH];
   res_type  res_ff;
   res_type  res_in;

   logic [33:0] tz_ext;
   logic [33:0] tz60;
   logic [33:0] loc_w;
   logic [16:0] sod;
   logic [16:0] wk;
   logic [5:0]  oct_sum;
   logic [3:0]  wk_fold;
   logic [3:0]  wk_sub;
   logic [17:0] yoe_prod;
   logic [1:0]  cent;
   logic [17:0] yoe_sub;
   logic [17:0] doy_w;
   logic [10:0] mp_arg;
   logic [8:0]  mstart;
   logic [8:0]  day_w;
   logic [3:0]  month_w;
   div8_type    dv_day_hi;
   div8_type    dv_day_lo;
   div8_type    dv_hour;
   div8_type    dv_minute;
   div8_type    dv_4y;
   div8_type    dv_yoe_hi;
   div8_type    dv_yoe_lo;
   div8_type    dv_month;

   u2c_pipe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .out_stall   (rsp_stall),
      .load        (load),
      .stage_valid (stage_valid)
   );

   assign req_stall = ~load[0];
   assign rsp_valid = stage_valid[ST_OUT];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff <= 1'b0;
         unix_ff   <= '0;
         mono_ff   <= '0;
         zone_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNCED:       synced_ff <= csr_wdata[0];
            CSR_UNIX_SECONDS: unix_ff   <= csr_wdata[31:0];
            CSR_MONOTONIC_US: mono_ff   <= csr_wdata[TIME_WIDTH-1:0];
            CSR_ZONE_OFFSET:  zone_ff   <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign diff_w = {1'b0, req_now_microseconds} - {1'b0, mono_ff};
   assign ok0_in = synced_ff & ~diff_w[63];
   assign xp0_in = {7'b0, diff_w[62:6]};

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ok_ff[0]  <= ok0_in;
         xp_ff[0]  <= xp0_in;
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_us_div
      div8_type step_res;
      assign step_res = div8({2'b0, rem_ff[k-1]}, xp_ff[k-1][(DIV_STAGES-k)*8+7 -: 8],
                             US_DIVISOR);
      always_ff @(posedge clock) begin
         if (load[k]) begin
            ok_ff[k]  <= ok_ff[k-1];
            xp_ff[k]  <= xp_ff[k-1];
            rem_ff[k] <= step_res.rem[13:0];
            q_ff[k]   <= {q_ff[k-1][23:0], step_res.quo};
         end
      end
   end

   always_comb begin
      p_in[ST_UTC]     = '0;
      p_in[ST_UTC].ok  = ok_ff[DIV_STAGES];
      p_in[ST_UTC].utc = unix_ff + q_ff[DIV_STAGES];

      tz_ext = {{23{zone_ff[10]}}, zone_ff};
      tz60   = (tz_ext << 6) - (tz_ext << 2);
      loc_w  = {2'b0, p_ff[ST_UTC].utc} + tz60;
      p_in[ST_LOCAL]     = p_ff[ST_UTC];
      p_in[ST_LOCAL].ok  = p_ff[ST_UTC].ok & ~loc_w[33];
      p_in[ST_LOCAL].loc = loc_w[32:0];

      dv_day_hi = div8({6'b0, p_ff[ST_LOCAL].loc[32:23]}, p_ff[ST_LOCAL].loc[22:15],
                       DAY_DIVISOR);
      p_in[ST_DAY_HI]      = p_ff[ST_LOCAL];
      p_in[ST_DAY_HI].drem = dv_day_hi.rem[9:0];
      p_in[ST_DAY_HI].days = {8'b0, dv_day_hi.quo};

      dv_day_lo = div8({6'b0, p_ff[ST_DAY_HI].drem}, p_ff[ST_DAY_HI].loc[14:7], DAY_DIVISOR);
      p_in[ST_DAY_LO]      = p_ff[ST_DAY_HI];
      p_in[ST_DAY_LO].drem = dv_day_lo.rem[9:0];
      p_in[ST_DAY_LO].days = {p_ff[ST_DAY_HI].days[7:0], dv_day_lo.quo};

      sod     = {p_ff[ST_DAY_LO].drem, p_ff[ST_DAY_LO].loc[6:0]};
      dv_hour = div8({7'b0, sod[16:8]}, sod[7:0], SEC_PER_HOUR);
      wk      = {1'b0, p_ff[ST_DAY_LO].days} + WEEKDAY_SHIFT;
      oct_sum = {4'b0, wk[16:15]} + {3'b0, wk[14:12]} + {3'b0, wk[11:9]}
              + {3'b0, wk[8:6]} + {3'b0, wk[5:3]} + {3'b0, wk[2:0]};
      wk_fold = {1'b0, oct_sum[5:3]} + {1'b0, oct_sum[2:0]};
      wk_sub  = wk_fold - 4'd7;
      p_in[ST_SPLIT]         = p_ff[ST_DAY_LO];
      p_in[ST_SPLIT].hour    = dv_hour.quo[4:0];
      p_in[ST_SPLIT].r3600   = dv_hour.rem[11:0];
      p_in[ST_SPLIT].weekday = (wk_fold >= 4'd7) ? wk_sub[2:0] : wk_fold[2:0];
      p_in[ST_SPLIT].era_hi  = p_ff[ST_DAY_LO].days >= ERA_SPLIT_DAYS;
      if (p_ff[ST_DAY_LO].days >= ERA_SPLIT_DAYS) begin
         p_in[ST_SPLIT].doe = {2'b0, p_ff[ST_DAY_LO].days} - ERA_HI_OFFSET;
      end else begin
         p_in[ST_SPLIT].doe = {2'b0, p_ff[ST_DAY_LO].days} + ERA_LO_OFFSET;
      end

      dv_minute = div8({12'b0, p_ff[ST_SPLIT].r3600[11:8]}, p_ff[ST_SPLIT].r3600[7:0],
                       SEC_PER_MINUTE);
      dv_4y     = div8({6'b0, p_ff[ST_SPLIT].doe[17:8]}, p_ff[ST_SPLIT].doe[7:0], DAYS_PER_4Y);
      p_in[ST_CLOCK]          = p_ff[ST_SPLIT];
      p_in[ST_CLOCK].minute   = dv_minute.quo[5:0];
      p_in[ST_CLOCK].second   = dv_minute.rem[5:0];
      p_in[ST_CLOCK].q1460    = dv_4y.quo[6:0];
      p_in[ST_CLOCK].q36524   = {2'b0, p_ff[ST_SPLIT].doe >= DOE_CENTURY_1}
                              + {2'b0, p_ff[ST_SPLIT].doe >= DOE_CENTURY_2}
                              + {2'b0, p_ff[ST_SPLIT].doe >= DOE_CENTURY_3}
                              + {2'b0, p_ff[ST_SPLIT].doe >= DOE_LAST_DAY};
      p_in[ST_CLOCK].last_day = p_ff[ST_SPLIT].doe == DOE_LAST_DAY;

      p_in[ST_NUM]     = p_ff[ST_CLOCK];
      p_in[ST_NUM].num = p_ff[ST_CLOCK].doe - {11'b0, p_ff[ST_CLOCK].q1460}
                       + {15'b0, p_ff[ST_CLOCK].q36524} - {17'b0, p_ff[ST_CLOCK].last_day};

      dv_yoe_hi = div8({14'b0, p_ff[ST_NUM].num[17:16]}, p_ff[ST_NUM].num[15:8],
                       DAYS_PER_YEAR);
      p_in[ST_YOE_HI]       = p_ff[ST_NUM];
      p_in[ST_YOE_HI].yq_hi = dv_yoe_hi.quo;
      p_in[ST_YOE_HI].yrem  = dv_yoe_hi.rem[8:0];

      dv_yoe_lo = div8({7'b0, p_ff[ST_YOE_HI].yrem}, p_ff[ST_YOE_HI].num[7:0], DAYS_PER_YEAR);
      p_in[ST_YOE_LO]     = p_ff[ST_YOE_HI];
      p_in[ST_YOE_LO].yoe = {p_ff[ST_YOE_HI].yq_hi[0], dv_yoe_lo.quo};

      yoe_prod = {9'b0, p_ff[ST_YOE_LO].yoe} * YEAR_DAYS_MUL;
      cent     = {1'b0, p_ff[ST_YOE_LO].yoe >= 9'd100} + {1'b0, p_ff[ST_YOE_LO].yoe >= 9'd200}
               + {1'b0, p_ff[ST_YOE_LO].yoe >= 9'd300};
      yoe_sub  = yoe_prod + {11'b0, p_ff[ST_YOE_LO].yoe[8:2]} - {16'b0, cent};
      doy_w    = p_ff[ST_YOE_LO].doe - yoe_sub;
      p_in[ST_DOY]           = p_ff[ST_YOE_LO];
      p_in[ST_DOY].doy       = doy_w[8:0];
      p_in[ST_DOY].year_base = {3'b0, p_ff[ST_YOE_LO].yoe}
                             + (p_ff[ST_YOE_LO].era_hi ? ERA_HI_YEAR : ERA_LO_YEAR);

      mp_arg   = {p_ff[ST_DOY].doy, 2'b0} + {2'b0, p_ff[ST_DOY].doy} + 11'd2;
      dv_month = div8({13'b0, mp_arg[10:8]}, mp_arg[7:0], MONTH_SPAN);
      p_in[ST_MONTH]    = p_ff[ST_DOY];
      p_in[ST_MONTH].mp = dv_month.quo[3:0];

      mstart  = month_start(p_ff[ST_MONTH].mp);
      day_w   = p_ff[ST_MONTH].doy - mstart + 9'd1;
      month_w = (p_ff[ST_MONTH].mp < 4'd10) ? p_ff[ST_MONTH].mp + 4'd3
                                            : p_ff[ST_MONTH].mp - 4'd9;
      res_in  = '0;
      if (p_ff[ST_MONTH].ok) begin
         res_in.valid_res    = 1'b1;
         res_in.year         = p_ff[ST_MONTH].year_base + {11'b0, month_w <= 4'd2};
         res_in.month        = month_w;
         res_in.day_of_month = day_w[4:0];
         res_in.hour         = p_ff[ST_MONTH].hour;
         res_in.minute       = p_ff[ST_MONTH].minute;
         res_in.second       = p_ff[ST_MONTH].second;
         res_in.weekday      = p_ff[ST_MONTH].weekday;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = ST_UTC; i <= ST_MONTH; i++) begin
         if (load[i]) begin
            p_ff[i] <= p_in[i];
         end
      end
      if (load[ST_OUT]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid_res    = res_ff.valid_res;
   assign rsp_year         = res_ff.year;
   assign rsp_month        = res_ff.month;
   assign rsp_day_of_month = res_ff.day_of_month;
   assign rsp_hour         = res_ff.hour;
   assign rsp_minute       = res_ff.minute;
   assign rsp_second       = res_ff.second;
   assign rsp_weekday      = res_ff.weekday;

endmodule

>>> design/u2c_pipe_ctrl.sv
module u2c_pipe_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic                            out_stall,
   output logic [u2c_pkg::NUM_STAGES-1:0]  load,
   output logic [u2c_pkg::NUM_STAGES-1:0]  stage_valid
);
   import u2c_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] hole;
   logic [NUM_STAGES-1:0] prev_valid;

   assign prev_valid = {valid_ff[NUM_STAGES-2:0], in_valid};

   // A stage may load when the output is not stalled or some stage at or after it is empty.
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         hole[i]     = |(~valid_ff & ({NUM_STAGES{1'b1}} << i));
         load[i]     = ~out_stall | hole[i];
         valid_in[i] = load[i] ? prev_valid[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign stage_valid = valid_ff;

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !out_stall |-> &load)
      else $error("pipeline held although the output is free");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && load[0] |=> stage_valid[0])
      else $error("accepted transfer missing from the first stage");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (&stage_valid) && out_stall |=> &stage_valid)
      else $error("full stalled pipeline lost an item");

endmodule
